// File: design/fat_pkg.sv
// ----------------------------------------------------------------------------
// fat_pkg
// Shared types and constants for the FAT table entry engine.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

package fat_pkg;

  localparam int STORE_BYTES = 8192;
  localparam int ADDR_W      = $clog2(STORE_BYTES);
  localparam int OFF_W       = 14;
  localparam int QUEUE_DEPTH = 2;

  localparam logic [11:0] MAX_COUNT  = 12'd4094;
  localparam logic [11:0] FIRST_CLU  = 12'd2;
  localparam logic [11:0] MASK12     = 12'hFFF;
  localparam logic [11:0] RESV_MASK  = 12'hFF0;
  localparam logic [15:0] SIGN_EXT   = 16'hF000;
  localparam logic [15:0] EOC_MIN    = 16'hFFF8;
  localparam logic [7:0]  LOW_NIB    = 8'h0F;
  localparam logic [7:0]  HIGH_NIB   = 8'hF0;

  typedef enum logic [1:0] {
    OP_READ  = 2'd0,
    OP_WRITE = 2'd1,
    OP_FIND  = 2'd2,
    OP_STATS = 2'd3
  } op_t;

  typedef enum logic {
    REG_MODE  = 1'b0,
    REG_COUNT = 1'b1
  } reg_idx_t;

  typedef struct packed {
    logic        fat16;
    logic [11:0] last;
  } cfg_t;

  typedef struct packed {
    op_t         op;
    logic [11:0] cluster;
    logic [15:0] data;
    logic        oor;
  } item_t;

endpackage

// File: design/fat_ram.sv
// ----------------------------------------------------------------------------
// fat_ram
// Single-port RAM with registered read data.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] addr,
  input  logic [WIDTH-1:0]         wdata,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    rdata <= mem[addr];
  end

endmodule

// File: design/fat_front.sv
// ----------------------------------------------------------------------------
// fat_front
// Accepts command words, checks the cluster range and queues them.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_front (
  input  logic                clk,
  input  logic                rst,
  input  logic                push,
  input  logic [1:0]          opcode,
  input  logic [11:0]         cluster,
  input  logic [15:0]         entry_data,
  input  fat_pkg::cfg_t       cfg,
  input  logic                pop,
  output logic                full,
  output logic                empty,
  output fat_pkg::item_t      head
);
  import fat_pkg::*;

  item_t      q [QUEUE_DEPTH];
  logic       wptr;
  logic       rptr;
  logic [1:0] count;
  item_t      incoming;

  always_comb begin
    incoming.op      = op_t'(opcode);
    incoming.cluster = cluster;
    incoming.data    = entry_data;
    incoming.oor     = (cluster < FIRST_CLU) || (cluster > cfg.last);
  end

  assign full  = (count == 2'(QUEUE_DEPTH));
  assign empty = (count == 2'd0);
  assign head  = q[rptr];

  always_ff @(posedge clk) begin
    if (push) begin
      q[wptr] <= incoming;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      wptr  <= 1'b0;
      rptr  <= 1'b0;
      count <= 2'd0;
    end else begin
      if (push) begin
        wptr <= ~wptr;
      end
      if (pop) begin
        rptr <= ~rptr;
      end
      count <= count + 2'(push) - 2'(pop);
    end
  end

  a_no_overflow: assert property (@(posedge clk) disable iff (rst) push |-> !full)
    else $error("command word pushed into a full queue");
  a_no_underflow: assert property (@(posedge clk) disable iff (rst) pop |-> !empty)
    else $error("command word popped from an empty queue");
  a_count_track: assert property (@(posedge clk) disable iff (rst)
    (push && !pop) |=> (count == $past(count) + 2'd1))
    else $error("queue count did not follow a push");

endmodule

// File: design/fat_back.sv
// ----------------------------------------------------------------------------
// fat_back
// Executes queued commands against the byte store, one byte access a cycle.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module fat_back (
  input  logic                clk,
  input  logic                rst,
  input  fat_pkg::cfg_t       cfg,
  input  logic                empty,
  input  fat_pkg::item_t      head,
  output logic                pop,
  output logic                clearing,
  output logic                done,
  output logic [15:0]         entry_value,
  output logic [11:0]         free_cluster,
  output logic [11:0]         free_total,
  output logic [11:0]         bad_total,
  output logic [11:0]         used_total,
  output logic [11:0]         highest_used,
  output logic                status
);
  import fat_pkg::*;

  typedef enum logic [3:0] {
    S_CLEAR, S_IDLE, S_RA, S_RB, S_RC, S_EV, S_W0, S_W1
  } state_t;

  state_t            state;
  item_t             cur;
  logic [11:0]       idx;
  logic [12:0]       hint;
  logic [11:0]       first;
  logic [7:0]        lo;
  logic [7:0]        hi;
  logic              lo_ok;
  logic              hi_ok;
  logic [ADDR_W-1:0] clr_addr;

  logic [OFF_W-1:0]  off;
  logic [OFF_W-1:0]  off1;
  logic              off_in;
  logic              off1_in;
  logic [15:0]       word;
  logic [11:0]       w12;
  logic [15:0]       entry;
  logic [11:0]       v12;
  logic              ram_we;
  logic [ADDR_W-1:0] ram_addr;
  logic [7:0]        ram_wdata;
  logic [7:0]        ram_rdata;

  always_comb begin
    if (cfg.fat16) begin
      off = {1'b0, idx, 1'b0};
    end else begin
      off = OFF_W'(idx) + OFF_W'(idx[11:1]);
    end
    off1    = off + OFF_W'(1);
    off_in  = (32'(off) < STORE_BYTES);
    off1_in = (32'(off1) < STORE_BYTES);
    word    = {hi, lo};
    w12     = idx[0] ? word[15:4] : word[11:0];
    if (cfg.fat16) begin
      entry = word;
    end else if ((w12 & RESV_MASK) == RESV_MASK) begin
      entry = SIGN_EXT | {4'h0, w12};
    end else begin
      entry = {4'h0, w12};
    end
    v12 = cur.data[11:0] & MASK12;
  end

  always_comb begin
    ram_we    = 1'b0;
    ram_addr  = ADDR_W'(off);
    ram_wdata = 8'h00;
    unique case (state)
      S_CLEAR: begin
        ram_we   = 1'b1;
        ram_addr = clr_addr;
      end
      S_RB: begin
        ram_addr = ADDR_W'(off1);
      end
      S_W0: begin
        ram_we = off_in;
        if (cfg.fat16) begin
          ram_wdata = cur.data[7:0];
        end else if (idx[0]) begin
          ram_wdata = (lo & LOW_NIB) | {v12[3:0], 4'h0};
        end else begin
          ram_wdata = v12[7:0];
        end
      end
      S_W1: begin
        ram_we   = off1_in;
        ram_addr = ADDR_W'(off1);
        if (cfg.fat16) begin
          ram_wdata = cur.data[15:8];
        end else if (idx[0]) begin
          ram_wdata = v12[11:4];
        end else begin
          ram_wdata = (hi & HIGH_NIB) | {4'h0, v12[11:8]};
        end
      end
      default: begin
      end
    endcase
  end

  assign pop      = (state == S_IDLE) && !empty;
  assign clearing = (state == S_CLEAR);

  fat_ram #(.WIDTH(8), .DEPTH(STORE_BYTES)) u_store (
    .clk   (clk),
    .we    (ram_we),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  always_ff @(posedge clk) begin
    if (rst) begin
      state        <= S_CLEAR;
      clr_addr     <= '0;
      hint         <= 13'd2;
      done         <= 1'b0;
      status       <= 1'b0;
      entry_value  <= '0;
      free_cluster <= '0;
      free_total   <= '0;
      bad_total    <= '0;
      used_total   <= '0;
      highest_used <= '0;
    end else begin
      done <= 1'b0;
      unique case (state)
        S_CLEAR: begin
          clr_addr <= clr_addr + ADDR_W'(1);
          if (clr_addr == '1) begin
            state <= S_IDLE;
          end
        end
        S_IDLE: begin
          if (!empty) begin
            cur          <= head;
            status       <= 1'b0;
            entry_value  <= '0;
            free_cluster <= '0;
            free_total   <= '0;
            bad_total    <= '0;
            used_total   <= '0;
            highest_used <= '0;
            first        <= '0;
            unique case (head.op)
              OP_READ, OP_WRITE: begin
                if (head.oor) begin
                  status <= 1'b1;
                  done   <= 1'b1;
                end else begin
                  idx   <= head.cluster;
                  state <= S_RA;
                end
              end
              OP_FIND: begin
                if (hint > {1'b0, cfg.last}) begin
                  done <= 1'b1;
                end else begin
                  idx   <= hint[11:0];
                  state <= S_RA;
                end
              end
              OP_STATS: begin
                if (cfg.last < FIRST_CLU) begin
                  hint <= {1'b0, cfg.last} + 13'd1;
                  done <= 1'b1;
                end else begin
                  idx   <= FIRST_CLU;
                  state <= S_RA;
                end
              end
            endcase
          end
        end
        S_RA: begin
          lo_ok <= off_in;
          state <= S_RB;
        end
        S_RB: begin
          lo    <= lo_ok ? ram_rdata : 8'h00;
          hi_ok <= off1_in;
          state <= S_RC;
        end
        S_RC: begin
          hi    <= hi_ok ? ram_rdata : 8'h00;
          state <= S_EV;
        end
        S_EV: begin
          unique case (cur.op)
            OP_READ: begin
              entry_value <= entry;
              done        <= 1'b1;
              state       <= S_IDLE;
            end
            OP_WRITE: begin
              state <= S_W0;
            end
            OP_FIND: begin
              if (entry == 16'h0000) begin
                free_cluster <= idx;
                hint         <= {1'b0, idx} + 13'd1;
                done         <= 1'b1;
                state        <= S_IDLE;
              end else if (idx == cfg.last) begin
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                idx   <= idx + 12'd1;
                state <= S_RA;
              end
            end
            OP_STATS: begin
              if (entry == 16'h0000) begin
                free_total <= free_total + 12'd1;
                if (first == 12'd0) begin
                  first <= idx;
                end
              end else if (entry < EOC_MIN && entry > {4'h0, cfg.last}) begin
                bad_total <= bad_total + 12'd1;
              end else begin
                used_total   <= used_total + 12'd1;
                highest_used <= idx;
              end
              if (idx == cfg.last) begin
                // the first free cluster may be the one just classified
                if (first != 12'd0) begin
                  hint <= {1'b0, first};
                end else if (entry == 16'h0000) begin
                  hint <= {1'b0, idx};
                end else begin
                  hint <= {1'b0, cfg.last} + 13'd1;
                end
                done  <= 1'b1;
                state <= S_IDLE;
              end else begin
                idx   <= idx + 12'd1;
                state <= S_RA;
              end
            end
          endcase
        end
        S_W0: begin
          state <= S_W1;
        end
        S_W1: begin
          if ((cfg.fat16 ? (cur.data == 16'h0000) : (v12 == 12'h000)) &&
              ({1'b0, idx} < hint)) begin
            hint <= {1'b0, idx};
          end
          done  <= 1'b1;
          state <= S_IDLE;
        end
        default: begin
          state <= S_IDLE;
        end
      endcase
    end
  end

  a_no_done_clear: assert property (@(posedge clk) disable iff (rst) done |-> !clearing)
    else $error("result word given during the clearing pass");
  a_we_states: assert property (@(posedge clk) disable iff (rst)
    ram_we |-> (state == S_CLEAR || state == S_W0 || state == S_W1))
    else $error("store written outside a write step");
  a_status_op: assert property (@(posedge clk) disable iff (rst)
    (done && status) |-> (cur.op == OP_READ || cur.op == OP_WRITE))
    else $error("range flag raised on a scan command");
  a_hint_low: assert property (@(posedge clk) disable iff (rst)
    !clearing |-> (hint >= 13'd2))
    else $error("free hint fell below the first data cluster");

endmodule

// File: design/fat_table_entry_engine_top.sv
// ----------------------------------------------------------------------------
// fat_table_entry_engine_top
// FAT12/FAT16 table entry engine with an APB register port.
// ----------------------------------------------------------------------------
// After reset the engine clears its 8192-byte store, one byte a cycle, and busy
// stays high until that pass is over, so no command word is taken before then. A
// read fetches the entry's two bytes and then forms the entry, and a write then
// stores two bytes back; find and statistics read every cluster they visit,
// since each entry costs two accesses on the single byte-wide store port plus a
// classify step. A two-word queue lets start be taken while a command runs;
// after the clearing pass busy is high only when that queue is full. Each
// result is valid in the one cycle in which done is high and may be replaced
// right after it; the receiver cannot hold it off and must take it in that cycle.
`timescale 1ns / 1ps

module fat_table_entry_engine_top (
  input  logic        clk,
  input  logic        rst,
  input  logic        psel,
  input  logic        penable,
  input  logic        pwrite,
  input  logic [2:0]  paddr,
  input  logic [31:0] pwdata,
  output logic [31:0] prdata,
  output logic        pready,
  input  logic        start,
  output logic        busy,
  input  logic [1:0]  opcode,
  input  logic [11:0] cluster,
  input  logic [15:0] entry_data,
  output logic        done,
  output logic [15:0] entry_value,
  output logic [11:0] free_cluster,
  output logic [11:0] free_total,
  output logic [11:0] bad_total,
  output logic [11:0] used_total,
  output logic [11:0] highest_used,
  output logic        status
);
  import fat_pkg::*;

  logic        fat16_mode;
  logic [11:0] cluster_count;
  cfg_t        cfg;
  logic        wr_en;
  logic        push;
  logic        pop;
  logic        full;
  logic        empty;
  logic        clearing;
  item_t       head;

  assign pready = 1'b1;
  assign wr_en  = psel && penable && pwrite;

  always_ff @(posedge clk) begin
    if (rst) begin
      fat16_mode    <= 1'b0;
      cluster_count <= MAX_COUNT;
    end else if (wr_en) begin
      unique case (reg_idx_t'(paddr[2]))
        REG_MODE:  fat16_mode    <= pwdata[0];
        REG_COUNT: cluster_count <= pwdata[11:0];
      endcase
    end
  end

  always_comb begin
    unique case (reg_idx_t'(paddr[2]))
      REG_MODE:  prdata = {31'h0, fat16_mode};
      REG_COUNT: prdata = {20'h0, cluster_count};
    endcase
  end

  always_comb begin
    cfg.fat16 = fat16_mode;
    cfg.last  = ((cluster_count > MAX_COUNT) ? MAX_COUNT : cluster_count) + 12'd1;
  end

  assign busy = full || clearing;
  assign push = start && !busy;

  fat_front u_front (
    .clk        (clk),
    .rst        (rst),
    .push       (push),
    .opcode     (opcode),
    .cluster    (cluster),
    .entry_data (entry_data),
    .cfg        (cfg),
    .pop        (pop),
    .full       (full),
    .empty      (empty),
    .head       (head)
  );

  fat_back u_back (
    .clk          (clk),
    .rst          (rst),
    .cfg          (cfg),
    .empty        (empty),
    .head         (head),
    .pop          (pop),
    .clearing     (clearing),
    .done         (done),
    .entry_value  (entry_value),
    .free_cluster (free_cluster),
    .free_total   (free_total),
    .bad_total    (bad_total),
    .used_total   (used_total),
    .highest_used (highest_used),
    .status       (status)
  );

endmodule

// File: sim/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for the FAT table entry engine: it sets the mode and
// cluster count over the APB port, sends read, write, find and statistics
// words, and checks every result against a byte-level model of the table.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
  import fat_pkg::*;

  class fat_scoreboard;

    typedef struct {
      logic [15:0] entry_value;
      logic [11:0] free_cluster;
      logic [11:0] free_total;
      logic [11:0] bad_total;
      logic [11:0] used_total;
      logic [11:0] highest_used;
      logic        status;
    } fat_result_t;

    logic [7:0]  table_bytes [STORE_BYTES];
    int unsigned hint;
    bit          fat16;
    int unsigned count;
    fat_result_t pending [$];
    int          errors;

    function void clear();
      foreach (table_bytes[i]) table_bytes[i] = 8'h00;
      hint = 2;
      fat16 = 1'b0;
      count = 4094;
      errors = 0;
    endfunction

    function int unsigned last_cluster();
      return ((count > 4094) ? 4094 : count) + 1;
    endfunction

    function int unsigned get_b(int unsigned a);
      return (a < STORE_BYTES) ? table_bytes[a] : 0;
    endfunction

    function void put_b(int unsigned a, int unsigned v);
      if (a < STORE_BYTES) table_bytes[a] = v[7:0];
    endfunction

    function int unsigned entry_of(int unsigned c);
      int unsigned off, w;
      if (fat16) begin
        off = c * 2;
        return get_b(off) | (get_b(off + 1) << 8);
      end
      off = c * 3 / 2;
      w = get_b(off) | (get_b(off + 1) << 8);
      w = c[0] ? (w >> 4) : (w & 32'hFFF);
      if ((w & 32'hFF0) == 32'hFF0) w |= 32'hF000;
      return w & 32'hFFFF;
    endfunction

    function void store_entry(int unsigned c, int unsigned v);
      int unsigned off;
      if (fat16) begin
        off = c * 2;
        put_b(off, v);
        put_b(off + 1, v >> 8);
      end else begin
        off = c * 3 / 2;
        v &= 32'hFFF;
        if (c[0]) begin
          put_b(off, (get_b(off) & 32'hF) | ((v << 4) & 32'hF0));
          put_b(off + 1, v >> 4);
        end else begin
          put_b(off, v);
          put_b(off + 1, (get_b(off + 1) & 32'hF0) | (v >> 8));
        end
      end
    endfunction

    function void note(op_t op, logic [11:0] clu, logic [15:0] data);
      fat_result_t r;
      int unsigned last, e, first, ft, bt, ut, lu, stored;
      bit hit;
      last = last_cluster();
      r = '{default: '0};
      ft = 0; bt = 0; ut = 0; lu = 0; first = 0;
      hit = (clu >= 2) && (clu <= last);
      case (op)
        OP_READ: begin
          if (hit) r.entry_value = 16'(entry_of(clu));
          else r.status = 1'b1;
        end
        OP_WRITE: begin
          if (hit) begin
            stored = fat16 ? data : (data & 16'hFFF);
            store_entry(clu, data);
            if (stored == 0 && clu < hint) hint = clu;
          end else begin
            r.status = 1'b1;
          end
        end
        OP_FIND: begin
          for (int unsigned i = hint; i <= last; i++) begin
            if (entry_of(i) == 0) begin
              hint = (i + 1) & 32'h1FFF;
              r.free_cluster = 12'(i);
              break;
            end
          end
        end
        default: begin
          for (int unsigned i = 2; i <= last; i++) begin
            e = entry_of(i);
            if (e == 0) begin
              ft++;
              if (first == 0) first = i;
            end else if (e < 32'hFFF8 && e > last) begin
              bt++;
            end else begin
              ut++;
              lu = i;
            end
          end
          hint = first ? first : last + 1;
          r.free_total = 12'(ft);
          r.bad_total = 12'(bt);
          r.used_total = 12'(ut);
          r.highest_used = 12'(lu);
        end
      endcase
      pending.push_back(r);
    endfunction

    function void check(fat_result_t got);
      fat_result_t want;
      if (pending.size() == 0) begin
        $display("%0t: result word with nothing expected", $time);
        errors++;
        return;
      end
      want = pending.pop_front();
      if (got.entry_value !== want.entry_value) begin
        $display("%0t: entry_value exp %h got %h", $time, want.entry_value,
                 got.entry_value);
        errors++;
      end
      if (got.free_cluster !== want.free_cluster) begin
        $display("%0t: free_cluster exp %0d got %0d", $time, want.free_cluster,
                 got.free_cluster);
        errors++;
      end
      if (got.free_total !== want.free_total) begin
        $display("%0t: free_total exp %0d got %0d", $time, want.free_total,
                 got.free_total);
        errors++;
      end
      if (got.bad_total !== want.bad_total) begin
        $display("%0t: bad_total exp %0d got %0d", $time, want.bad_total, got.bad_total);
        errors++;
      end
      if (got.used_total !== want.used_total) begin
        $display("%0t: used_total exp %0d got %0d", $time, want.used_total,
                 got.used_total);
        errors++;
      end
      if (got.highest_used !== want.highest_used) begin
        $display("%0t: highest_used exp %0d got %0d", $time, want.highest_used,
                 got.highest_used);
        errors++;
      end
      if (got.status !== want.status) begin
        $display("%0t: status exp %0b got %0b", $time, want.status, got.status);
        errors++;
      end
    endfunction

  endclass

  logic        clk;
  logic        rst;
  logic        psel, penable, pwrite;
  logic [2:0]  paddr;
  logic [31:0] pwdata;
  logic [31:0] prdata;
  logic        pready;
  logic        start;
  logic        busy;
  logic [1:0]  opcode;
  logic [11:0] cluster;
  logic [15:0] entry_data;
  logic        done;
  logic [15:0] entry_value;
  logic [11:0] free_cluster, free_total, bad_total, used_total, highest_used;
  logic        status;

  fat_scoreboard fat_sb;

  fat_table_entry_engine_top u_dut (.*);

  initial clk = 1'b0;
  always #5 clk = ~clk;

  always @(posedge clk) begin
    if (!rst && done) begin
      fat_sb.check('{entry_value, free_cluster, free_total, bad_total, used_total,
                     highest_used, status});
    end
  end

  task automatic write_reg(reg_idx_t idx, logic [31:0] value);
    @(negedge clk);
    psel = 1'b1; pwrite = 1'b1; penable = 1'b0;
    paddr = 3'(idx) << 2; pwdata = value;
    @(negedge clk);
    penable = 1'b1;
    @(posedge clk);
    if (idx == REG_MODE) fat_sb.fat16 = value[0];
    else fat_sb.count = value[11:0];
    @(negedge clk);
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0;
  endtask

  // Waits for every outstanding word, then a little longer for the queue to settle.
  task automatic drain();
    while (fat_sb.pending.size() != 0) @(posedge clk);
    repeat (10) @(posedge clk);
  endtask

  task automatic send_cmd(op_t op, logic [11:0] clu, logic [15:0] data);
    bit taken;
    @(negedge clk);
    start = 1'b1; opcode = op; cluster = clu; entry_data = data;
    taken = 1'b0;
    while (!taken) begin
      @(posedge clk);
      taken = !busy;
    end
    fat_sb.note(op, clu, data);
  endtask

  task automatic idle_gap();
    int unsigned roll, n;
    roll = $urandom_range(0, 99);
    if (roll < 50) return;
    n = (roll < 90) ? $urandom_range(1, 3) : $urandom_range(10, 40);
    @(negedge clk);
    start = 1'b0;
    repeat (n - 1) @(negedge clk);
  endtask

  task automatic random_cmd(bit quiet);
    int unsigned roll, last;
    op_t op;
    logic [11:0] clu;
    logic [15:0] data;
    last = fat_sb.last_cluster();
    roll = $urandom_range(0, 99);
    // Scans over a large table are slow, so they are rarer there.
    if (roll < 38) op = OP_READ;
    else if (roll < 85) op = OP_WRITE;
    else if (roll < 93) op = (quiet && roll > 86) ? OP_READ : OP_FIND;
    else op = (quiet && roll > 94) ? OP_WRITE : OP_STATS;
    if (last >= 2 && $urandom_range(0, 99) < 85) clu = 12'($urandom_range(2, last));
    else clu = 12'($urandom_range(0, 4095));
    roll = $urandom_range(0, 99);
    if (roll < 22) data = 16'h0000;
    else if (roll < 30) data = {4'($urandom_range(0, 15)), 12'h000};
    else if (roll < 55) data = 16'($urandom_range(2, last + 1));
    else if (roll < 65) data = 16'($urandom_range(16'hFF0, 16'hFFF));
    else if (roll < 75) data = 16'($urandom_range(16'hFFF0, 16'hFFFF));
    else data = 16'($urandom_range(0, 16'hFFFF));
    send_cmd(op, clu, data);
  endtask

  int unsigned counts [12] = '{1, 5, 16, 40, 100, 300, 0, 12, 64, 200, 4095, 2};

  initial begin
    fat_sb = new();
    fat_sb.clear();
    rst = 1'b1;
    psel = 1'b0; penable = 1'b0; pwrite = 1'b0; paddr = '0; pwdata = '0;
    start = 1'b0; opcode = OP_READ; cluster = '0; entry_data = '0;
    repeat (4) @(posedge clk);
    @(negedge clk);
    rst = 1'b0;

    // Reset settings: packed 12-bit entries over the full table.
    send_cmd(OP_READ, 12'd2, 16'h0000);
    send_cmd(OP_WRITE, 12'd2, 16'hFFFF);
    send_cmd(OP_READ, 12'd2, 16'h0000);
    send_cmd(OP_WRITE, 12'd3, 16'h0ABC);
    send_cmd(OP_READ, 12'd3, 16'h0000);
    send_cmd(OP_READ, 12'd2, 16'h0000);
    send_cmd(OP_WRITE, 12'd4095, 16'h5123);
    send_cmd(OP_READ, 12'd4095, 16'h0000);
    send_cmd(OP_WRITE, 12'd4094, 16'h0FF5);
    send_cmd(OP_READ, 12'd4094, 16'h0000);
    send_cmd(OP_READ, 12'd0, 16'h0000);
    send_cmd(OP_WRITE, 12'd1, 16'h0777);
    send_cmd(OP_READ, 12'd1, 16'h0000);
    send_cmd(OP_FIND, 12'd0, 16'h0000);
    send_cmd(OP_WRITE, 12'd4, 16'h1000);
    send_cmd(OP_FIND, 12'd0, 16'h0000);
    send_cmd(OP_WRITE, 12'd5, 16'h0FF7);
    send_cmd(OP_WRITE, 12'd6, 16'h0FF8);
    send_cmd(OP_STATS, 12'd0, 16'h0000);
    send_cmd(OP_FIND, 12'd0, 16'h0000);
    @(negedge clk);
    start = 1'b0;
    drain();

    for (int p = 0; p < 12; p++) begin
      write_reg(REG_MODE, p % 2);
      write_reg(REG_COUNT, counts[p]);
      for (int k = 0; k < 158; k++) begin
        if (p == 3 && k == 80) begin
          @(negedge clk);
          start = 1'b0;
          while (fat_sb.pending.size() != 0) @(posedge clk);
        end
        random_cmd(fat_sb.last_cluster() > 400);
        idle_gap();
      end
      // A table with no free cluster, so that find and statistics run dry.
      if (p == 4) begin
        for (int c = 2; c <= 101; c++) send_cmd(OP_WRITE, 12'(c), 16'hFFFF);
        send_cmd(OP_FIND, 12'd0, 16'h0000);
        send_cmd(OP_STATS, 12'd0, 16'h0000);
        send_cmd(OP_FIND, 12'd0, 16'h0000);
      end
      @(negedge clk);
      start = 1'b0;
      drain();
    end

    if (fat_sb.errors == 0) begin
      $display("fat_table_entry_engine_top verification clean");
    end else begin
      $display("fat_table_entry_engine_top verification failed");
    end
    $finish;
  end

  initial begin
    #20ms;
    $display("fat_table_entry_engine_top verification failed");
    $finish;
  end

endmodule
